// ===== design/dcf_pkg.sv =====
// Shared types, constants and widths for the decimating complex FIR core.
// No dependencies; every other design file except dcf_ram imports this package.
`default_nettype none

package dcf_pkg;

    // tap store and delay line depth
    localparam int MAX_TAPS  = 64;
    localparam int AW        = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TAPS_W    = $clog2(MAX_TAPS + 1);
    localparam int BASE_W    = AW + 2;

    // field and register widths
    localparam int DATA_W    = 16;
    localparam int TIDX_W    = 6;
    localparam int DECIM_W   = 9;
    localparam int TCNT_W    = 7;
    localparam int PHASE_W   = 8;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int DECIM_MAX = 256;

    // arithmetic
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + AW;
    localparam int Q_SHIFT   = 15;
    localparam int SAT_MAX   = 32767;
    localparam int SAT_MIN   = -32768;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECIM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS  = 1'd1;

    // request codes
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TAP    = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FIN
    } t_state;

    // control travelling alongside the memory read data
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
        logic hvld;
        logic cvld;
    } t_mac_ctl;

endpackage

`default_nettype wire

// ===== design/decimating_complex_fir_q15_core.sv =====
// Top level of the decimating complex FIR: sequencer, delay line and tap RAMs,
// and the shared multiply-accumulate unit. Uses dcf_pkg, dcf_seq, dcf_ram, dcf_mac.
// A sample that produces an output holds the input stalled while its T taps run
// (T = taps in use, one tap per cycle through the single MAC) and the MAC drains,
// longer while an earlier result still waits in the output register; its result
// is then loaded into the output register. Other samples and tap writes do not stall.
// Synchronous active-low reset idles the sequencer and zeroes all entries via valid bits.
`default_nettype none

module decimating_complex_fir_q15_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_req_type,
    input  wire logic signed [dcf_pkg::DATA_W-1:0] i_sample_re,
    input  wire logic signed [dcf_pkg::DATA_W-1:0] i_sample_im,
    input  wire logic [dcf_pkg::TIDX_W-1:0]        i_tap_index,
    input  wire logic signed [dcf_pkg::DATA_W-1:0] i_tap_value,
    input  wire logic                              i_cfg_we,
    input  wire logic [dcf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [dcf_pkg::CFG_W-1:0]         i_cfg_wdata,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [dcf_pkg::DATA_W-1:0]      o_out_re,
    output logic signed [dcf_pkg::DATA_W-1:0]      o_out_im
);
    import dcf_pkg::*;

    logic                     hist_we;
    logic [AW-1:0]            hist_waddr;
    logic [2*DATA_W-1:0]      hist_wdata;
    logic [AW-1:0]            hist_raddr;
    logic [2*DATA_W-1:0]      hist_rdata;
    logic                     coef_we;
    logic [AW-1:0]            coef_waddr;
    logic [DATA_W-1:0]        coef_wdata;
    logic [AW-1:0]            coef_raddr;
    logic [DATA_W-1:0]        coef_rdata;
    t_mac_ctl                 mac_ctl;
    logic                     mac_done;
    logic signed [DATA_W-1:0] res_re;
    logic signed [DATA_W-1:0] res_im;

    // control and handshakes
    dcf_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_sample_re  (i_sample_re),
        .i_sample_im  (i_sample_im),
        .i_tap_index  (i_tap_index),
        .i_tap_value  (i_tap_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_hist_we    (hist_we),
        .o_hist_waddr (hist_waddr),
        .o_hist_wdata (hist_wdata),
        .o_hist_raddr (hist_raddr),
        .o_coef_we    (coef_we),
        .o_coef_waddr (coef_waddr),
        .o_coef_wdata (coef_wdata),
        .o_coef_raddr (coef_raddr),
        .o_ctl        (mac_ctl),
        .i_mac_done   (mac_done),
        .i_res_re     (res_re),
        .i_res_im     (res_im),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_re     (o_out_re),
        .o_out_im     (o_out_im)
    );

    // delay line, I and Q side by side
    dcf_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    // tap store
    dcf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (coef_wdata),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    // shared multiply-accumulate
    dcf_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mac_ctl),
        .i_hist_re (hist_rdata[2*DATA_W-1:DATA_W]),
        .i_hist_im (hist_rdata[DATA_W-1:0]),
        .i_coef    (coef_rdata),
        .o_done    (mac_done),
        .o_res_re  (res_re),
        .o_res_im  (res_im)
    );

endmodule

`default_nettype wire

// ===== design/dcf_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module dcf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                             i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/dcf_mac.sv =====
// Shared complex-by-real multiply-accumulate unit with scaling and saturation.
// Depends on dcf_pkg.
`default_nettype none

module dcf_mac (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire dcf_pkg::t_mac_ctl                 i_ctl,
    input  wire logic signed [dcf_pkg::DATA_W-1:0] i_hist_re,
    input  wire logic signed [dcf_pkg::DATA_W-1:0] i_hist_im,
    input  wire logic signed [dcf_pkg::DATA_W-1:0] i_coef,
    output logic                                   o_done,
    output logic signed [dcf_pkg::DATA_W-1:0]      o_res_re,
    output logic signed [dcf_pkg::DATA_W-1:0]      o_res_im
);
    import dcf_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SAT_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(SAT_MIN);

    logic signed [DATA_W-1:0] op_c;
    logic signed [DATA_W-1:0] op_re;
    logic signed [DATA_W-1:0] op_im;
    logic signed [PROD_W-1:0] r_prod_re;
    logic signed [PROD_W-1:0] r_prod_im;
    t_mac_ctl                 r_s2;
    logic signed [ACC_W-1:0]  r_acc_re;
    logic signed [ACC_W-1:0]  r_acc_im;
    logic signed [ACC_W-1:0]  n_acc_re;
    logic signed [ACC_W-1:0]  n_acc_im;
    logic signed [ACC_W-1:0]  sh_re;
    logic signed [ACC_W-1:0]  sh_im;

    // entries never written read as zero
    assign op_c  = i_ctl.cvld ? i_coef    : '0;
    assign op_re = i_ctl.hvld ? i_hist_re : '0;
    assign op_im = i_ctl.hvld ? i_hist_im : '0;

    // product stage
    always_ff @(posedge i_clk) begin
        r_prod_re <= PROD_W'(op_c) * PROD_W'(op_re);
        r_prod_im <= PROD_W'(op_c) * PROD_W'(op_im);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= i_ctl;
        end
    end

    // accumulate stage, restarted on the first tap
    always_comb begin
        n_acc_re = r_s2.first ? '0 : r_acc_re;
        n_acc_im = r_s2.first ? '0 : r_acc_im;
        n_acc_re = n_acc_re + {{(ACC_W-PROD_W){r_prod_re[PROD_W-1]}}, r_prod_re};
        n_acc_im = n_acc_im + {{(ACC_W-PROD_W){r_prod_im[PROD_W-1]}}, r_prod_im};
    end

    always_ff @(posedge i_clk) begin
        if (r_s2.vld) begin
            r_acc_re <= n_acc_re;
            r_acc_im <= n_acc_im;
        end
    end

    // done flags the last tap as it commits; sums are final on the cycle after
    assign o_done = r_s2.vld && r_s2.last;

    // floor scaling and saturation to the output range
    assign sh_re = r_acc_re >>> Q_SHIFT;
    assign sh_im = r_acc_im >>> Q_SHIFT;

    always_comb begin
        if (sh_re > SAT_HI) begin
            o_res_re = SAT_HI[DATA_W-1:0];
        end else if (sh_re < SAT_LO) begin
            o_res_re = SAT_LO[DATA_W-1:0];
        end else begin
            o_res_re = sh_re[DATA_W-1:0];
        end
        if (sh_im > SAT_HI) begin
            o_res_im = SAT_HI[DATA_W-1:0];
        end else if (sh_im < SAT_LO) begin
            o_res_im = SAT_LO[DATA_W-1:0];
        end else begin
            o_res_im = sh_im[DATA_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== design/dcf_seq.sv =====
// Sequencer: handshakes, configuration registers, delay line pointer, decimation
// phase, valid bits, tap address generation and output register. Uses dcf_pkg.
`default_nettype none

module dcf_seq (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_req_type,
    input  wire logic signed [dcf_pkg::DATA_W-1:0] i_sample_re,
    input  wire logic signed [dcf_pkg::DATA_W-1:0] i_sample_im,
    input  wire logic [dcf_pkg::TIDX_W-1:0]        i_tap_index,
    input  wire logic signed [dcf_pkg::DATA_W-1:0] i_tap_value,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [dcf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [dcf_pkg::CFG_W-1:0]         i_cfg_wdata,
    // memories
    output logic                                   o_hist_we,
    output logic [dcf_pkg::AW-1:0]                 o_hist_waddr,
    output logic [2*dcf_pkg::DATA_W-1:0]           o_hist_wdata,
    output logic [dcf_pkg::AW-1:0]                 o_hist_raddr,
    output logic                                   o_coef_we,
    output logic [dcf_pkg::AW-1:0]                 o_coef_waddr,
    output logic [dcf_pkg::DATA_W-1:0]             o_coef_wdata,
    output logic [dcf_pkg::AW-1:0]                 o_coef_raddr,
    // mac unit
    output dcf_pkg::t_mac_ctl                      o_ctl,
    input  wire logic                              i_mac_done,
    input  wire logic signed [dcf_pkg::DATA_W-1:0] i_res_re,
    input  wire logic signed [dcf_pkg::DATA_W-1:0] i_res_im,
    // output channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [dcf_pkg::DATA_W-1:0]      o_out_re,
    output logic signed [dcf_pkg::DATA_W-1:0]      o_out_im
);
    import dcf_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [DECIM_W-1:0]  r_decim;
    logic [TCNT_W-1:0]   r_tcnt;
    logic [AW-1:0]       r_ptr;
    logic [AW-1:0]       n_ptr;
    logic [PHASE_W-1:0]  r_phase;
    logic [PHASE_W-1:0]  n_phase;
    logic [AW-1:0]       r_k;
    logic [AW-1:0]       n_k;
    logic [AW-1:0]       r_klast;
    logic [AW-1:0]       n_klast;
    logic [AW-1:0]       r_pos;
    logic [AW-1:0]       n_pos;
    logic [MAX_TAPS-1:0] r_hist_vld;
    logic [MAX_TAPS-1:0] r_coef_vld;
    t_mac_ctl            r_ctl;
    t_mac_ctl            n_ctl;
    logic                r_out_vld;
    logic                n_out_vld;

    logic                in_acc;
    logic                is_sample;
    logic                emit;
    logic                last_k;
    logic                load_out;
    logic                tap_in_range;
    logic [31:0]         tidx_ext;
    logic [TAPS_W-1:0]   taps_eff;
    logic [DECIM_W-1:0]  decim_eff;
    logic [DECIM_W-1:0]  phase_inc;
    logic [BASE_W-1:0]   base_sum;
    logic [BASE_W-1:0]   base_mod;

    // transaction acceptance
    assign in_acc    = i_in_valid && (r_state == ST_IDLE);
    assign is_sample = (i_req_type == REQ_SAMPLE);
    assign emit      = (r_phase == '0);
    assign last_k    = (r_k == r_klast);

    // clamp the configuration to its working range
    always_comb begin
        if (r_tcnt == '0) begin
            taps_eff = TAPS_W'(1);
        end else if (32'(r_tcnt) > MAX_TAPS) begin
            taps_eff = TAPS_W'(MAX_TAPS);
        end else begin
            taps_eff = TAPS_W'(r_tcnt);
        end
        if (r_decim == '0) begin
            decim_eff = DECIM_W'(1);
        end else if (32'(r_decim) > DECIM_MAX) begin
            decim_eff = DECIM_W'(DECIM_MAX);
        end else begin
            decim_eff = r_decim;
        end
    end

    // oldest sample in the window: newest minus (taps - 1), wrapped
    assign base_sum = BASE_W'(r_ptr) + BASE_W'(MAX_TAPS) - BASE_W'(taps_eff) + BASE_W'(1);
    assign base_mod = (base_sum >= BASE_W'(MAX_TAPS)) ? base_sum - BASE_W'(MAX_TAPS)
                                                       : base_sum;
    assign phase_inc = DECIM_W'(r_phase) + DECIM_W'(1);

    // tap index check
    assign tidx_ext     = 32'(i_tap_index);
    assign tap_in_range = (tidx_ext < MAX_TAPS);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && is_sample && emit) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_k) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_mac_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        o_hist_we  = 1'b0;
        o_coef_we  = 1'b0;
        load_out   = 1'b0;
        n_ctl      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_hist_we  = in_acc && is_sample;
                o_coef_we  = in_acc && !is_sample && tap_in_range;
            end
            ST_RUN: begin
                n_ctl.vld   = 1'b1;
                n_ctl.first = (r_k == '0);
                n_ctl.last  = last_k;
                n_ctl.hvld  = r_hist_vld[r_pos];
                n_ctl.cvld  = r_coef_vld[r_k];
            end
            ST_DRAIN: begin
                n_ctl = '0;
            end
            ST_FIN: begin
                load_out = !r_out_vld || !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // memory ports
    assign o_hist_waddr = r_ptr;
    assign o_hist_wdata = {i_sample_re, i_sample_im};
    assign o_hist_raddr = r_pos;
    assign o_coef_waddr = tidx_ext[AW-1:0];
    assign o_coef_wdata = i_tap_value;
    assign o_coef_raddr = r_k;
    assign o_ctl        = r_ctl;

    // pointer, phase and tap counters
    always_comb begin
        n_ptr   = r_ptr;
        n_phase = r_phase;
        n_k     = r_k;
        n_klast = r_klast;
        n_pos   = r_pos;
        if (in_acc && is_sample) begin
            n_ptr   = (r_ptr == AW'(MAX_TAPS - 1)) ? '0 : r_ptr + AW'(1);
            n_phase = (phase_inc >= decim_eff) ? '0 : phase_inc[PHASE_W-1:0];
            n_k     = '0;
            n_klast = AW'(taps_eff - TAPS_W'(1));
            n_pos   = base_mod[AW-1:0];
        end else if (r_state == ST_RUN) begin
            n_k   = r_k + AW'(1);
            n_pos = (r_pos == AW'(MAX_TAPS - 1)) ? '0 : r_pos + AW'(1);
        end
    end

    // output register occupancy
    always_comb begin
        n_out_vld = r_out_vld;
        if (load_out) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_decim    <= DECIM_W'(1);
            r_tcnt     <= TCNT_W'(1);
            r_ptr      <= '0;
            r_phase    <= '0;
            r_k        <= '0;
            r_klast    <= '0;
            r_pos      <= '0;
            r_hist_vld <= '0;
            r_coef_vld <= '0;
            r_ctl      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_phase   <= n_phase;
            r_k       <= n_k;
            r_klast   <= n_klast;
            r_pos     <= n_pos;
            r_ctl     <= n_ctl;
            r_out_vld <= n_out_vld;
            if (o_hist_we) begin
                r_hist_vld[r_ptr] <= 1'b1;
            end
            if (o_coef_we) begin
                r_coef_vld[tidx_ext[AW-1:0]] <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DECIM: r_decim <= i_cfg_wdata[DECIM_W-1:0];
                    CFG_TAPS:  r_tcnt  <= i_cfg_wdata[TCNT_W-1:0];
                    default: begin
                        r_decim <= r_decim;
                    end
                endcase
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_out_re <= i_res_re;
            o_out_im <= i_res_im;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

`default_nettype wire

// ===== design/dcf_chk.sv =====
// Port-level checks for the decimating complex FIR core, bound to the top level.
// Depends on dcf_pkg and decimating_complex_fir_q15_core.
`default_nettype none

module dcf_chk (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              o_in_stall,
    input wire logic                              i_req_type,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_stall,
    input wire logic signed [dcf_pkg::DATA_W-1:0] o_out_re,
    input wire logic signed [dcf_pkg::DATA_W-1:0] o_out_im
);
    import dcf_pkg::*;

    // reset leaves the block idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    // a tap write never starts a computation
    a_tap_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_req_type == REQ_TAP) |=> !o_in_stall)
        else $error("tap write made the block busy");

    // a result only appears at the end of a busy computation
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a computation");

    // pending result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output transaction dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_re) && $stable(o_out_im))
        else $error("output payload changed under stall");

endmodule

bind decimating_complex_fir_q15_core dcf_chk u_dcf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_req_type  (i_req_type),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_re    (o_out_re),
    .o_out_im    (o_out_im)
);

`default_nettype wire
